[rtl/assert_macros.svh]
// Assertion helpers shared by the mixer RTL.
// Both macros sample on clock and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/smx_pkg.sv]
// Shared types and constants for the eight-channel stereo mixer.
// No dependencies.
`timescale 1ns / 1ps

package smx_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 24;
   localparam int FRAC_BITS    = 28;

   localparam int MASTER_W   = 16;
   localparam int VOL_W      = 8;
   localparam int PAN_W      = 8;
   localparam int MASK_W     = 8;
   localparam int WEIGHT_W   = 9;
   localparam int MV_W       = MASTER_W + VOL_W;
   localparam int GAIN_W     = 32;
   localparam int PROD_W     = GAIN_W + SAMPLE_BITS;
   localparam int ACC_W      = PROD_W + $clog2(NUM_CHANNELS);
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam logic [MASTER_W-1:0]   MASTER_RESET = 16'd16384;
   localparam logic [CSR_DATA_W-1:0] VOLS_RESET   = 64'h8080_8080_8080_8080;
   localparam logic [CSR_DATA_W-1:0] PANS_RESET   = '0;
   localparam logic [MASK_W-1:0]     MASK_RESET   = '0;
   localparam logic signed [PAN_W+1:0] PAN_ONE    = 10'sd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MASTER = 3'd0,
      REG_VOLS   = 3'd1,
      REG_PANS   = 3'd2,
      REG_MUTE   = 3'd3,
      REG_SOLO   = 3'd4
   } reg_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [GAIN_W-1:0]             gain_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [ACC_W-1:0]       acc_type;

   localparam acc_type ACC_ROUND = acc_type'(64'd1 << (FRAC_BITS - 1));

   typedef struct packed {
      gain_type left;
      gain_type right;
   } gain_pair_type;

   // One frame in flight along the cell chain.
   typedef struct packed {
      logic                           valid;
      logic                           last;
      sample_type [NUM_CHANNELS-1:0]  samples;
      acc_type                        acc_l;
      acc_type                        acc_r;
      prod_type                       prod_l;
      prod_type                       prod_r;
   } stage_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       last;
   } mix_type;

endpackage

[rtl/smx_csr.sv]
// Configuration registers and per-channel left/right gain computation.
// Depends on smx_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smx_csr (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_we,
   input  logic [smx_pkg::CSR_IDX_W-1:0]              csr_index,
   input  logic [smx_pkg::CSR_DATA_W-1:0]             csr_data,
   output smx_pkg::gain_pair_type [smx_pkg::NUM_CHANNELS-1:0] gains
);
   import smx_pkg::*;

   logic [MASTER_W-1:0]   master_ff, master_in;
   logic [CSR_DATA_W-1:0] vols_ff, vols_in;
   logic [CSR_DATA_W-1:0] pans_ff, pans_in;
   logic [MASK_W-1:0]     mute_ff, mute_in;
   logic [MASK_W-1:0]     solo_ff, solo_in;

   logic [MV_W-1:0]           mv_ff [NUM_CHANNELS];
   logic [MV_W-1:0]           mv_in [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]   en_ff, en_in;
   gain_pair_type [NUM_CHANNELS-1:0] gain_ff, gain_in;

   logic                      any_solo;

   // Reset is folded into the next-value logic so the gain stages also
   // see the reset settings.
   always_comb begin
      master_in = master_ff;
      vols_in   = vols_ff;
      pans_in   = pans_ff;
      mute_in   = mute_ff;
      solo_in   = solo_ff;
      if (reset) begin
         master_in = MASTER_RESET;
         vols_in   = VOLS_RESET;
         pans_in   = PANS_RESET;
         mute_in   = MASK_RESET;
         solo_in   = MASK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MASTER: master_in = csr_data[MASTER_W-1:0];
            REG_VOLS:   vols_in   = csr_data;
            REG_PANS:   pans_in   = csr_data;
            REG_MUTE:   mute_in   = csr_data[MASK_W-1:0];
            REG_SOLO:   solo_in   = csr_data[MASK_W-1:0];
            default:    ;
         endcase
      end
   end

   assign any_solo = |solo_in[NUM_CHANNELS-1:0];

   // Master times volume is taken from the incoming values so that it is
   // registered alongside the settings and the gains are registered from it.
   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         mv_in[i] = MV_W'(master_in) * MV_W'(vols_in[VOL_W*i +: VOL_W]);
         en_in[i] = !mute_in[i] && (!any_solo || solo_in[i]);
      end
   end

   always_comb begin
      logic signed [PAN_W+1:0] pan_x;
      logic signed [PAN_W+1:0] w_l;
      logic signed [PAN_W+1:0] w_r;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         pan_x = (PAN_W+2)'($signed(pans_ff[PAN_W*i +: PAN_W]));
         w_l   = PAN_ONE - pan_x;
         w_r   = PAN_ONE + pan_x;
         if (en_ff[i]) begin
            gain_in[i].left  = GAIN_W'(mv_ff[i]) * GAIN_W'(w_l[WEIGHT_W-1:0]);
            gain_in[i].right = GAIN_W'(mv_ff[i]) * GAIN_W'(w_r[WEIGHT_W-1:0]);
         end else begin
            gain_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      master_ff <= master_in;
      vols_ff   <= vols_in;
      pans_ff   <= pans_in;
      mute_ff   <= mute_in;
      solo_ff   <= solo_in;
      en_ff     <= en_in;
      mv_ff     <= mv_in;
      gain_ff   <= gain_in;
   end

   assign gains = gain_ff;

   `ASSERT_IMP(a_all_muted_silent, (mute_ff[NUM_CHANNELS-1:0] == '1) && $past(mute_ff[NUM_CHANNELS-1:0] == '1), gain_ff == '0, "muted channels left a nonzero gain")

endmodule

[rtl/smx_cell.sv]
// One mixer cell: multiplies one channel by its gains and adds the
// previous channel's products into the running sums. Depends on smx_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smx_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  smx_pkg::gain_pair_type gain,
   input  smx_pkg::stage_type     stage_i,
   output smx_pkg::stage_type     stage_o
);
   import smx_pkg::*;

   stage_type stage_ff, stage_in;
   logic signed [PROD_W:0] mul_l;
   logic signed [PROD_W:0] mul_r;

   assign mul_l = (PROD_W+1)'($signed({1'b0, gain.left})) *
                  (PROD_W+1)'($signed(stage_i.samples[0]));
   assign mul_r = (PROD_W+1)'($signed({1'b0, gain.right})) *
                  (PROD_W+1)'($signed(stage_i.samples[0]));

   always_comb begin
      stage_in.valid   = stage_i.valid;
      stage_in.last    = stage_i.last;
      // The next cell always finds its channel at the bottom of the row.
      stage_in.samples = stage_i.samples >> SAMPLE_BITS;
      stage_in.acc_l   = stage_i.acc_l + acc_type'(stage_i.prod_l);
      stage_in.acc_r   = stage_i.acc_r + acc_type'(stage_i.prod_r);
      stage_in.prod_l  = $signed(mul_l[PROD_W-1:0]);
      stage_in.prod_r  = $signed(mul_r[PROD_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

   `ASSERT_NXT(a_cell_moves, adv, stage_o.valid == $past(stage_i.valid), "cell lost or made a beat")

endmodule

[rtl/smx_out.sv]
// Final sum, rounding and saturation, followed by the output register
// and a skid stage that decouples the chain. Depends on smx_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smx_out (
   input  logic                clock,
   input  logic                reset,
   input  smx_pkg::stage_type  stage_i,
   output logic                adv,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output smx_pkg::sample_type rsp_mix_left,
   output smx_pkg::sample_type rsp_mix_right,
   output logic                rsp_block_end
);
   import smx_pkg::*;

   localparam int Q_W = ACC_W - FRAC_BITS;
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

   function automatic sample_type sat(input acc_type total);
      logic signed [Q_W-1:0] q;
      q = $signed(total[ACC_W-1:FRAC_BITS]);
      if (q > Q_MAX) begin
         return Q_MAX[SAMPLE_BITS-1:0];
      end else if (q < Q_MIN) begin
         return Q_MIN[SAMPLE_BITS-1:0];
      end
      return q[SAMPLE_BITS-1:0];
   endfunction

   mix_type main_ff, main_in, skid_ff, skid_in, mix;
   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    push, take;

   // The rounding constant was loaded into the sums at the chain entry.
   always_comb begin
      mix.left  = sat(stage_i.acc_l + acc_type'(stage_i.prod_l));
      mix.right = sat(stage_i.acc_r + acc_type'(stage_i.prod_r));
      mix.last  = stage_i.last;
   end

   assign adv  = !skid_valid_ff;
   assign push = adv && stage_i.valid;
   assign take = main_valid_ff && !rsp_stall;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_in       = mix;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = mix;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = main_valid_ff;
   assign rsp_mix_left  = main_ff.left;
   assign rsp_mix_right = main_ff.right;
   assign rsp_block_end = main_ff.last;

   `ASSERT_IMP(a_skid_behind_main, skid_valid_ff, main_valid_ff, "skid holds a beat while output is empty")
   `ASSERT_NXT(a_skid_drains, skid_valid_ff && !rsp_stall, !skid_valid_ff, "skid did not drain on a taken beat")

endmodule

[rtl/stereo_mixer_8ch_mute_solo_pan.sv]
// Eight-channel stereo mixer with mute, solo and pan.
// Beats go through the entry register, multiply-accumulate cells and output register.
// Throughput: one frame per cycle through the cell row while the skid stage is empty.
// Users must make configuration writes only while idle; the block does not enforce it.
// Reset (synchronous) empties the pipeline and loads the default register values.
`timescale 1ns / 1ps

module stereo_mixer_8ch_mute_solo_pan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  smx_pkg::sample_type                 req_sample_ch0,
   input  smx_pkg::sample_type                 req_sample_ch1,
   input  smx_pkg::sample_type                 req_sample_ch2,
   input  smx_pkg::sample_type                 req_sample_ch3,
   input  smx_pkg::sample_type                 req_sample_ch4,
   input  smx_pkg::sample_type                 req_sample_ch5,
   input  smx_pkg::sample_type                 req_sample_ch6,
   input  smx_pkg::sample_type                 req_sample_ch7,
   input  logic                                req_frame_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output smx_pkg::sample_type                 rsp_mix_left,
   output smx_pkg::sample_type                 rsp_mix_right,
   output logic                                rsp_block_end,
   input  logic                                csr_we,
   input  logic [smx_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [smx_pkg::CSR_DATA_W-1:0]      csr_data
);
   import smx_pkg::*;

   gain_pair_type [NUM_CHANNELS-1:0] gains;
   stage_type stage_w [NUM_CHANNELS+1];
   stage_type entry_ff, entry_in;
   logic      adv;

   assign req_stall = !adv || reset;

   always_comb begin
      entry_in.valid   = req_valid && !req_stall;
      entry_in.last    = req_frame_last;
      entry_in.samples = {req_sample_ch7, req_sample_ch6, req_sample_ch5, req_sample_ch4,
                          req_sample_ch3, req_sample_ch2, req_sample_ch1, req_sample_ch0};
      entry_in.acc_l   = ACC_ROUND;
      entry_in.acc_r   = ACC_ROUND;
      entry_in.prod_l  = '0;
      entry_in.prod_r  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (adv) begin
         entry_ff <= entry_in;
      end
   end

   assign stage_w[0] = entry_ff;

   smx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .gains     (gains)
   );

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
      smx_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .gain    (gains[i]),
         .stage_i (stage_w[i]),
         .stage_o (stage_w[i+1])
      );
   end

   smx_out u_out (
      .clock         (clock),
      .reset         (reset),
      .stage_i       (stage_w[NUM_CHANNELS]),
      .adv           (adv),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_mix_left  (rsp_mix_left),
      .rsp_mix_right (rsp_mix_right),
      .rsp_block_end (rsp_block_end)
   );

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for the eight-channel stereo mixer with mute, solo and pan.
// Holds a bit-exact mix predictor in a small scoreboard class and drives the block with
// plain tasks. Depends on smx_pkg and stereo_mixer_8ch_mute_solo_pan.
`timescale 1ns / 1ps

module testbench;
   import smx_pkg::*;

   localparam int LATENCY          = NUM_CHANNELS + 1;
   localparam int LIMIT_CYCLES     = 500000;
   localparam int RANDOM_PHASES    = 27;
   localparam int FRAMES_PER_PHASE = 50;
   localparam logic [CSR_IDX_W-1:0] FIRST_UNUSED_INDEX = CSR_IDX_W'(REG_SOLO + 1);
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      sample_type [NUM_CHANNELS-1:0] smp;
      logic                          last;
   } frame_type;

   class mix_scoreboard;
      logic [MASTER_W-1:0]   master;
      logic [CSR_DATA_W-1:0] vols;
      logic [CSR_DATA_W-1:0] pans;
      logic [MASK_W-1:0]     mute;
      logic [MASK_W-1:0]     solo;
      mix_type               expected_mix[$];
      int                    errors;

      function new();
         master = MASTER_RESET;
         vols   = VOLS_RESET;
         pans   = PANS_RESET;
         mute   = MASK_RESET;
         solo   = MASK_RESET;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_MASTER: master = data[MASTER_W-1:0];
            REG_VOLS:   vols   = data;
            REG_PANS:   pans   = data;
            REG_MUTE:   mute   = data[MASK_W-1:0];
            REG_SOLO:   solo   = data[MASK_W-1:0];
            default: ;
         endcase
      endfunction

      // Rounds a sum with FRAC_BITS fraction bits to nearest, ties upward, then clips.
      function sample_type round_and_clip(longint acc);
         longint r;
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
         lo = -hi - 1;
         r  = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         if (r > hi) r = hi;
         if (r < lo) r = lo;
         return sample_type'(r);
      endfunction

      function mix_type mix_frame(frame_type f);
         longint     acc_l;
         longint     acc_r;
         longint     gl;
         longint     gr;
         int         pan;
         int         vol;
         sample_type s;
         logic       any_solo;
         mix_type    m;
         acc_l    = 0;
         acc_r    = 0;
         any_solo = (solo != '0);
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (mute[ch] || (any_solo && !solo[ch])) continue;
            vol = vols[VOL_W*ch +: VOL_W];
            pan = $signed(pans[PAN_W*ch +: PAN_W]);
            gl  = longint'(master) * (int'(PAN_ONE) - pan) * vol;
            gr  = longint'(master) * (int'(PAN_ONE) + pan) * vol;
            s   = f.smp[ch];
            acc_l += gl * longint'(s);
            acc_r += gr * longint'(s);
         end
         m.left  = round_and_clip(acc_l);
         m.right = round_and_clip(acc_r);
         m.last  = f.last;
         return m;
      endfunction

      function void note_frame(frame_type f);
         expected_mix.push_back(mix_frame(f));
      endfunction

      function int pending();
         return expected_mix.size();
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_mix(mix_type got);
         mix_type want;
         if (expected_mix.size() == 0) begin
            report_mismatch("result beat with no frame outstanding");
            return;
         end
         want = expected_mix.pop_front();
         if (got.left !== want.left)
            report_mismatch($sformatf("mix_left got %0d, expected %0d", got.left, want.left));
         if (got.right !== want.right)
            report_mismatch($sformatf("mix_right got %0d, expected %0d",
                                      got.right, want.right));
         if (got.last !== want.last)
            report_mismatch($sformatf("block_end got %b, expected %b", got.last, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   sample_type req_sample_ch0, req_sample_ch1, req_sample_ch2, req_sample_ch3;
   sample_type req_sample_ch4, req_sample_ch5, req_sample_ch6, req_sample_ch7;
   logic req_frame_last;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sample_type rsp_mix_left;
   sample_type rsp_mix_right;
   logic rsp_block_end;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   mix_scoreboard sb;
   int req_gap_pct   = 30;
   int rsp_stall_pct = 30;
   int stall_left    = 0;
   int cycle_count   = 0;

   stereo_mixer_8ch_mute_solo_pan DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_ch0 (req_sample_ch0),
      .req_sample_ch1 (req_sample_ch1),
      .req_sample_ch2 (req_sample_ch2),
      .req_sample_ch3 (req_sample_ch3),
      .req_sample_ch4 (req_sample_ch4),
      .req_sample_ch5 (req_sample_ch5),
      .req_sample_ch6 (req_sample_ch6),
      .req_sample_ch7 (req_sample_ch7),
      .req_frame_last (req_frame_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mix_left   (rsp_mix_left),
      .rsp_mix_right  (rsp_mix_right),
      .rsp_block_end  (rsp_block_end),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // Register writes, accepted frames and result beats are all taken at the rising edge,
   // in that order, so the predictor always sees the setting the block used.
   always @(posedge clock) begin : monitor
      frame_type seen;
      mix_type   got;
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_data);
         if (req_valid && !req_stall) begin
            seen.smp  = {req_sample_ch7, req_sample_ch6, req_sample_ch5, req_sample_ch4,
                         req_sample_ch3, req_sample_ch2, req_sample_ch1, req_sample_ch0};
            seen.last = req_frame_last;
            sb.note_frame(seen);
         end
         if (rsp_valid && !rsp_stall) begin
            got.left  = rsp_mix_left;
            got.right = rsp_mix_right;
            got.last  = rsp_block_end;
            sb.check_mix(got);
         end
      end
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pick_idle(int pct);
      if (int'($urandom_range(0, 99)) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) stall_left = pick_idle(rsp_stall_pct);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   function automatic sample_type random_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return sample_type'(int'($urandom_range(0, 8)) - 4);
         3: return '0;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) f.smp[ch] = random_sample();
      f.last = ($urandom_range(0, 7) == 0);
      return f;
   endfunction

   function automatic frame_type frame_of(sample_type s, logic last);
      frame_type f;
      f.smp  = {NUM_CHANNELS{s}};
      f.last = last;
      return f;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_lanes(logic [7:0] a, logic [7:0] b,
                                                        logic [7:0] c);
      logic [CSR_DATA_W-1:0] v;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         case ($urandom_range(0, 3))
            0: v[8*i +: 8] = a;
            1: v[8*i +: 8] = b;
            2: v[8*i +: 8] = c;
            default: v[8*i +: 8] = 8'($urandom);
         endcase
      end
      return v;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_frame(input frame_type f);
      int gap;
      gap = pick_idle(req_gap_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_sample_ch7, req_sample_ch6, req_sample_ch5, req_sample_ch4,
       req_sample_ch3, req_sample_ch2, req_sample_ch1, req_sample_ch0} <= f.smp;
      req_frame_last <= f.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic enter_config();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
   endtask

   // The gains are registered from the settings, so let them follow before frames resume.
   task automatic leave_config();
      csr_we <= 1'b0;
      repeat (2) @(negedge clock);
   endtask

   task automatic random_setup();
      logic [CSR_DATA_W-1:0] data;
      enter_config();
      data = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: data[MASTER_W-1:0] = '0;
         1: data[MASTER_W-1:0] = '1;
         2: data[MASTER_W-1:0] = MASTER_RESET;
         3: data[MASTER_W-1:0] = MASTER_RESET >> 1;
         default: ;
      endcase
      csr_write(REG_MASTER, data);
      csr_write(REG_VOLS, pick_lanes(8'h00, 8'hFF, 8'h80));
      csr_write(REG_PANS, pick_lanes(8'h80, 8'h7F, 8'h00));
      data = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) data[MASK_W-1:0] = '0;
      csr_write(REG_MUTE, data);
      data = {$urandom, $urandom};
      if ($urandom_range(0, 4) < 3) data[MASK_W-1:0] = '0;
      csr_write(REG_SOLO, data);
      if ($urandom_range(0, 3) == 0)
         csr_write(CSR_IDX_W'($urandom_range(FIRST_UNUSED_INDEX, (1 << CSR_IDX_W) - 1)),
                   {$urandom, $urandom});
      leave_config();
      if ($urandom_range(0, 3) == 0) begin
         req_gap_pct   = 0;
         rsp_stall_pct = 0;
      end else begin
         req_gap_pct   = $urandom_range(0, 60);
         rsp_stall_pct = $urandom_range(0, 60);
      end
   endtask

   initial begin
      frame_type f;
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample_ch0 = '0;
      req_sample_ch1 = '0;
      req_sample_ch2 = '0;
      req_sample_ch3 = '0;
      req_sample_ch4 = '0;
      req_sample_ch5 = '0;
      req_sample_ch6 = '0;
      req_sample_ch7 = '0;
      req_frame_last = 1'b0;
      csr_we         = 1'b0;
      csr_index      = REG_MASTER;
      csr_data       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default setting: every channel at unity gain, centered, so full scale saturates.
      send_frame(frame_of('0, 1'b0));
      send_frame(frame_of(SAMPLE_MAX, 1'b0));
      send_frame(frame_of(SAMPLE_MIN, 1'b1));
      f = frame_of('0, 1'b1);
      f.smp[0] = SAMPLE_MAX;
      send_frame(f);
      f = frame_of('0, 1'b0);
      f.smp[NUM_CHANNELS-1] = SAMPLE_MIN;
      send_frame(f);
      for (int ch = 0; ch < NUM_CHANNELS; ch++) f.smp[ch] = ch[0] ? SAMPLE_MIN : SAMPLE_MAX;
      send_frame(f);
      send_frame(random_frame());

      // Half master gain puts odd sums exactly halfway between two output codes.
      // Bits above the master width and a write to an unused index must change nothing.
      enter_config();
      csr_write(REG_MASTER, {32'($urandom), 16'($urandom), MASTER_RESET >> 1});
      csr_write(FIRST_UNUSED_INDEX, {$urandom, $urandom});
      leave_config();
      f = frame_of('0, 1'b0);
      f.smp[0] = sample_type'(1);
      send_frame(f);
      f.smp[0] = sample_type'(-1);
      send_frame(f);
      f.smp[0] = sample_type'(-3);
      send_frame(f);
      f.smp[0] = sample_type'(3);
      f.smp[5] = sample_type'(-2);
      send_frame(f);

      // Largest gains, hard pans both ways, mutes, and solos that override the rest.
      enter_config();
      csr_write(REG_MASTER, '1);
      csr_write(REG_VOLS, '1);
      csr_write(REG_PANS, 64'h8081_7F00_807F_0180);
      csr_write(REG_MUTE, {56'hA5A5_5A5A_FFFF_00, 8'h05});
      csr_write(REG_SOLO, {56'h1234_5678_9ABC_DE, 8'h66});
      leave_config();
      send_frame(frame_of(SAMPLE_MAX, 1'b1));
      send_frame(frame_of(SAMPLE_MIN, 1'b0));
      send_frame(random_frame());
      f = frame_of('0, 1'b0);
      for (int ch = 0; ch < NUM_CHANNELS; ch++) f.smp[ch] = sample_type'(ch - 4);
      send_frame(f);

      // Zero master silences every channel.
      enter_config();
      csr_write(REG_MASTER, '0);
      leave_config();
      send_frame(frame_of(SAMPLE_MAX, 1'b0));
      send_frame(random_frame());

      // Everything muted, then a single soloed channel, then all volumes at zero.
      enter_config();
      csr_write(REG_MASTER, '1);
      csr_write(REG_MUTE, '1);
      csr_write(REG_SOLO, '0);
      leave_config();
      send_frame(frame_of(SAMPLE_MIN, 1'b1));
      enter_config();
      csr_write(REG_MUTE, '0);
      csr_write(REG_SOLO, 8'h80);
      csr_write(REG_VOLS, {NUM_CHANNELS{8'h7F}});
      leave_config();
      send_frame(frame_of(SAMPLE_MAX, 1'b0));
      send_frame(random_frame());
      enter_config();
      csr_write(REG_SOLO, '0);
      csr_write(REG_VOLS, '0);
      leave_config();
      send_frame(frame_of(SAMPLE_MAX, 1'b0));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_setup();
         for (int i = 0; i < FRAMES_PER_PHASE; i++) send_frame(random_frame());
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (2 * LATENCY) @(negedge clock);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[stereo_mixer_8ch_mute_solo_pan.f]
+incdir+rtl
rtl/smx_pkg.sv
rtl/smx_csr.sv
rtl/smx_cell.sv
rtl/smx_out.sv
rtl/stereo_mixer_8ch_mute_solo_pan.sv
tb/sv/testbench.sv
